[hw/rtl/csp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package csp_pkg;

    localparam int FRAME_BYTES_DEF = 8;

    typedef enum logic [2:0] {
        K_BOOL  = 3'd0,
        K_U8    = 3'd1,
        K_U16   = 3'd2,
        K_U32   = 3'd3,
        K_U64   = 3'd4,
        K_I32   = 3'd5,
        K_FLOAT = 3'd6,
        K_BAD   = 3'd7
    } t_kind;

    // double bit patterns of the range limits
    localparam logic [63:0] D_255     = 64'h406F_E000_0000_0000;
    localparam logic [63:0] D_65535   = 64'h40EF_FFE0_0000_0000;
    localparam logic [63:0] D_U32MAX  = 64'h41EF_FFFF_FFE0_0000;
    localparam logic [63:0] D_2P63    = 64'h43E0_0000_0000_0000;
    localparam logic [63:0] D_2P31    = 64'h41E0_0000_0000_0000;
    localparam logic [63:0] D_I32MAX  = 64'h41DF_FFFF_FFC0_0000;
    localparam logic [63:0] D_SGL_INF = 64'h47EF_FFFF_F000_0000;
    localparam logic [63:0] D_SGL_MAX = 64'h47EF_FFFF_E000_0000;

    typedef struct packed {
        logic [63:0] sample_bits;
        logic [63:0] bound_low_bits;
        logic [63:0] bound_high_bits;
        logic [2:0]  signal_kind;
        logic [5:0]  bit_position;
        logic [3:0]  byte_count;
        logic [3:0]  frame_length;
        logic [63:0] frame_in;
    } t_in;

    typedef struct packed {
        logic [63:0] frame_out;
        logic        insert_error;
    } t_out;

    typedef struct packed {
        logic        valid;
        logic        err;
        logic [63:0] frame;
        logic [63:0] sample;
        t_kind       kind;
        logic [3:0]  w;
        logic [2:0]  idx;
        logic [5:0]  pos;
        logic        sign;
        logic        nz;
        logic [52:0] sig;
        logic        left;
        logic [3:0]  lsh;
        logic [5:0]  rsh;
        logic [5:0]  fsh;
        logic [7:0]  fexp;
        logic        f_inf;
        logic        f_max;
    } t_s1;

    typedef struct packed {
        logic        valid;
        logic        err;
        logic [63:0] frame;
        t_kind       kind;
        logic [3:0]  w;
        logic [2:0]  idx;
        logic [5:0]  pos;
        logic        neg;
        logic        nz;
        logic [63:0] val;
    } t_s2;

    // ordering key of a non-NaN double; zeros of both signs compare equal
    function automatic logic d_lt(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ka;
        logic [63:0] kb;
        ka = a[63] ? ~a : {1'b1, a[62:0]};
        kb = b[63] ? ~b : {1'b1, b[62:0]};
        if (a[62:0] == 63'd0 && b[62:0] == 63'd0) begin
            return 1'b0;
        end
        return ka < kb;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/csp_check.sv]
`timescale 1ns / 1ps
`default_nettype none
module csp_check #(
    parameter int FRAME_BYTES = csp_pkg::FRAME_BYTES_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    input  csp_pkg::t_in  i_item,
    output csp_pkg::t_s1  o_s1
);
    import csp_pkg::*;

    localparam int CAP = (FRAME_BYTES < 8) ? FRAME_BYTES : 8;
    localparam logic [3:0] CAP4 = 4'(CAP);

    t_s1         n_s1;
    t_s1         r_s1;
    logic [63:0] x;
    logic [62:0] mag;
    logic [10:0] e;
    logic [3:0]  len;
    logic        lo_nan;
    logic        hi_nan;
    logic        e_bnd;
    logic        e_place;
    logic        e_rng;
    logic [4:0]  iw;
    logic signed [12:0] es;
    logic [12:0] fs;

    always_comb begin
        x      = i_item.sample_bits;
        mag    = x[62:0];
        e      = x[62:52];
        len    = (i_item.frame_length > CAP4) ? CAP4 : i_item.frame_length;
        lo_nan = (i_item.bound_low_bits[62:52] == 11'h7FF) &&
                 (i_item.bound_low_bits[51:0] != 52'd0);
        hi_nan = (i_item.bound_high_bits[62:52] == 11'h7FF) &&
                 (i_item.bound_high_bits[51:0] != 52'd0);
        e_bnd  = !lo_nan && !hi_nan &&
                 !d_lt(i_item.bound_high_bits, i_item.bound_low_bits) &&
                 (d_lt(x, i_item.bound_low_bits) || d_lt(i_item.bound_high_bits, x));

        n_s1       = '0;
        n_s1.valid = i_valid;
        n_s1.frame = i_item.frame_in;
        n_s1.sample = x;
        n_s1.kind  = t_kind'(i_item.signal_kind);
        n_s1.idx   = i_item.bit_position[5:3];
        n_s1.pos   = i_item.bit_position;
        n_s1.sign  = x[63];
        n_s1.nz    = (mag != 63'd0);
        n_s1.sig   = {(e != 11'd0), x[51:0]};

        e_place = 1'b0;
        e_rng   = 1'b0;
        case (t_kind'(i_item.signal_kind))
            K_U8, K_U16: n_s1.w = (i_item.byte_count == 4'd1) ? 4'd1 : 4'd2;
            K_U32, K_I32: n_s1.w = 4'd4;
            K_U64: n_s1.w = 4'd8;
            K_FLOAT: begin
                n_s1.w = i_item.byte_count;
                if (!(i_item.byte_count inside {4'd1, 4'd2, 4'd4, 4'd8})) begin
                    e_place = 1'b1;
                end
            end
            default: n_s1.w = 4'd1;
        endcase
        iw = {2'b0, n_s1.idx} + {1'b0, n_s1.w};

        if (t_kind'(i_item.signal_kind) == K_BOOL) begin
            e_place = ({1'b0, n_s1.idx} >= len);
        end else begin
            if (t_kind'(i_item.signal_kind) == K_BAD || i_item.bit_position[2:0] != 3'd0 ||
                iw > {1'b0, len}) begin
                e_place = 1'b1;
            end
            // range of the kind
            if (t_kind'(i_item.signal_kind) == K_I32) begin
                e_rng = x[63] ? (mag > D_2P31[62:0]) : (mag > D_I32MAX[62:0]);
            end else if (!(t_kind'(i_item.signal_kind) == K_FLOAT &&
                           (n_s1.w == 4'd8 || n_s1.w == 4'd4))) begin
                if (x[63] && n_s1.nz) begin
                    e_rng = 1'b1;
                end else if (!x[63]) begin
                    case (n_s1.w)
                        4'd1:    e_rng = mag > D_255[62:0];
                        4'd2:    e_rng = mag > D_65535[62:0];
                        4'd4:    e_rng = mag > D_U32MAX[62:0];
                        default: e_rng = mag >= D_2P63[62:0];
                    endcase
                end
            end
        end
        n_s1.err = (e == 11'h7FF) || e_bnd || e_place || e_rng;

        // integer rounding shifts
        n_s1.left = (e > 11'd1075);
        n_s1.lsh  = 4'(e - 11'd1075);
        n_s1.rsh  = (e < 11'd1022) ? 6'd54 : 6'(11'd1075 - e);

        // single conversion
        es = $signed({2'b0, e}) - 13'sd896;
        fs = 13'd0;
        if (es >= 13'sd1) begin
            n_s1.fexp = es[7:0];
            n_s1.fsh  = 6'd29;
        end else begin
            fs = 13'(13'sd30 - es);
            n_s1.fexp = 8'd0;
            n_s1.fsh  = (fs > 13'd63) ? 6'd63 : fs[5:0];
        end
        n_s1.f_inf = (mag >= D_SGL_INF[62:0]);
        n_s1.f_max = (mag > D_SGL_MAX[62:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= n_s1.valid;
        end
        r_s1.err    <= n_s1.err;
        r_s1.frame  <= n_s1.frame;
        r_s1.sample <= n_s1.sample;
        r_s1.kind   <= n_s1.kind;
        r_s1.w      <= n_s1.w;
        r_s1.idx    <= n_s1.idx;
        r_s1.pos    <= n_s1.pos;
        r_s1.sign   <= n_s1.sign;
        r_s1.nz     <= n_s1.nz;
        r_s1.sig    <= n_s1.sig;
        r_s1.left   <= n_s1.left;
        r_s1.lsh    <= n_s1.lsh;
        r_s1.rsh    <= n_s1.rsh;
        r_s1.fsh    <= n_s1.fsh;
        r_s1.fexp   <= n_s1.fexp;
        r_s1.f_inf  <= n_s1.f_inf;
        r_s1.f_max  <= n_s1.f_max;
    end

    assign o_s1 = r_s1;
endmodule
`default_nettype wire

[hw/rtl/csp_convert.sv]
`timescale 1ns / 1ps
`default_nettype none
module csp_convert (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  csp_pkg::t_s1  i_s1,
    output csp_pkg::t_s2  o_s2
);
    import csp_pkg::*;

    t_s2         n_s2;
    t_s2         r_s2;
    logic [53:0] ext;
    logic [63:0] t;
    logic        rb;
    logic [52:0] q;
    logic [52:0] lowm;
    logic        guard;
    logic        sticky;
    logic [30:0] sb;

    always_comb begin
        // round half away from zero
        ext = {i_s1.sig, 1'b0} >> i_s1.rsh;
        if (i_s1.left) begin
            t  = {11'd0, i_s1.sig} << i_s1.lsh;
            rb = 1'b0;
        end else begin
            t  = {11'd0, ext[53:1]};
            rb = ext[0];
        end

        // nearest even to single
        q      = i_s1.sig >> i_s1.fsh;
        guard  = |(i_s1.sig & (53'd1 << (i_s1.fsh - 6'd1)));
        lowm   = (53'd1 << (i_s1.fsh - 6'd1)) - 53'd1;
        sticky = |(i_s1.sig & lowm);
        sb     = {i_s1.fexp, q[22:0]} + {30'd0, guard && (sticky || q[0])};
        if (i_s1.f_inf) begin
            sb = 31'h7F80_0000;
        end else if (i_s1.f_max) begin
            sb = 31'h7F7F_FFFF;
        end

        n_s2       = '0;
        n_s2.valid = i_s1.valid;
        n_s2.err   = i_s1.err;
        n_s2.frame = i_s1.frame;
        n_s2.kind  = i_s1.kind;
        n_s2.w     = i_s1.w;
        n_s2.idx   = i_s1.idx;
        n_s2.pos   = i_s1.pos;
        n_s2.nz    = i_s1.nz;
        n_s2.neg   = (i_s1.kind == K_I32) && i_s1.sign;
        if (i_s1.kind == K_FLOAT && i_s1.w == 4'd8) begin
            n_s2.val = i_s1.sample;
        end else if (i_s1.kind == K_FLOAT && i_s1.w == 4'd4) begin
            n_s2.val = {32'd0, i_s1.sign, sb};
        end else begin
            n_s2.val = t + {63'd0, rb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid <= n_s2.valid;
        end
        r_s2.err   <= n_s2.err;
        r_s2.frame <= n_s2.frame;
        r_s2.kind  <= n_s2.kind;
        r_s2.w     <= n_s2.w;
        r_s2.idx   <= n_s2.idx;
        r_s2.pos   <= n_s2.pos;
        r_s2.neg   <= n_s2.neg;
        r_s2.nz    <= n_s2.nz;
        r_s2.val   <= n_s2.val;
    end

    assign o_s2 = r_s2;
endmodule
`default_nettype wire

[hw/rtl/csp_merge.sv]
`timescale 1ns / 1ps
`default_nettype none
module csp_merge (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  csp_pkg::t_s2  i_s2,
    output logic          o_done,
    output csp_pkg::t_out o_result
);
    import csp_pkg::*;

    logic [63:0] v;
    logic [15:0] bm;
    logic [63:0] m;
    logic [63:0] f;
    t_out        n_res;
    t_out        r_res;
    logic        r_done;

    always_comb begin
        v  = i_s2.neg ? (64'd0 - i_s2.val) : i_s2.val;
        bm = ((16'd1 << i_s2.w) - 16'd1) << i_s2.idx;
        for (int i = 0; i < 8; i++) begin
            m[i*8 +: 8] = {8{bm[i]}};
        end
        f = i_s2.frame;
        if (i_s2.kind == K_BOOL) begin
            f[i_s2.pos] = i_s2.nz;
        end else begin
            f = (f & ~m) | ((v << {i_s2.idx, 3'b000}) & m);
        end
        n_res.insert_error = i_s2.err;
        n_res.frame_out    = i_s2.err ? i_s2.frame : f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_s2.valid;
        end
        r_res <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;
endmodule
`default_nettype wire

[hw/rtl/can_signal_packer.sv]
`timescale 1ns / 1ps
`default_nettype none
// CAN signal packer: inserts one double sample into an 8-byte frame as a
// bool bit, a rounded little-endian integer or a single/double float, or
// flags an error and hands the frame back unchanged. Three register
// stages (check, convert, merge); busy is never raised, so an item may
// be started every cycle and its result strobes on o_done after the
// merge register. The receiver cannot stall: it must take each result
// in the cycle it is shown.
module can_signal_packer #(
    parameter int FRAME_BYTES = csp_pkg::FRAME_BYTES_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           start,
    output logic          busy,
    input  csp_pkg::t_in  i_item,
    output logic          o_done,
    output csp_pkg::t_out o_result
);
    import csp_pkg::*;

    t_s1 s1;
    t_s2 s2;

    // no state between items: always ready
    assign busy = 1'b0;

    // stage 1: finite, bounds, placement and range checks; shift setup
    csp_check #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_check (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(start && !busy),
        .i_item (i_item),
        .o_s1   (s1)
    );

    // stage 2: integer rounding and single-precision rounding
    csp_convert u_convert (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_s1   (s1),
        .o_s2   (s2)
    );

    // stage 3: sign, byte masking into the frame, result register
    csp_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s2    (s2),
        .o_done  (o_done),
        .o_result(o_result)
    );
endmodule
`default_nettype wire
